[design/dq_pkg.sv]
// Package for the double-ended queue block: field widths, request codes,
// controller state type and the command/status structs.
// No dependencies.
package dq_pkg;

    localparam int REQ_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int DATA_W         = 32;
    localparam int ENTRIES_W      = 5;
    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD  = 3'd0,
        REQ_INS_TAIL  = 3'd1,
        REQ_PEEK_HEAD = 3'd2,
        REQ_PEEK_TAIL = 3'd3,
        REQ_REM_HEAD  = 3'd4,
        REQ_REM_TAIL  = 3'd5
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_PEEK
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic issue_read;
        logic load_now;
        logic load_peek;
    } dq_cmd_t;

    typedef struct packed {
        logic peek_hit;
    } dq_status_t;

endpackage

[design/dq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/dq_ctrl.sv]
// Controller for the double-ended queue: request acceptance, peek wait
// state and the result-valid flag. Depends on dq_pkg.
module dq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  dq_pkg::dq_status_t status,
    output dq_pkg::dq_cmd_t    cmd
);
    import dq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && slot_free && status.peek_hit)
                begin
                    state_next = ST_PEEK;
                end
            end
            ST_PEEK:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready  = slot_free;
                cmd.accept     = s_axis_tvalid && slot_free;
                cmd.issue_read = cmd.accept && status.peek_hit;
                cmd.load_now   = cmd.accept && !status.peek_hit;
            end
            ST_PEEK:
            begin
                cmd.load_peek = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_now || cmd.load_peek)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/dq_datapath.sv]
// Datapath for the double-ended queue: head index, entry count, ring
// addressing, element store and result register. Depends on dq_pkg, dq_ram.
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = dq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dq_pkg::REQ_W-1:0]     req_type,
    input  logic [dq_pkg::VALUE_W-1:0]   value,
    input  dq_pkg::dq_cmd_t              cmd,
    output dq_pkg::dq_status_t           status,
    output logic                         ok,
    output logic [dq_pkg::DATA_W-1:0]    data,
    output logic [dq_pkg::ENTRIES_W-1:0] entries,
    output logic                         is_empty,
    output logic                         is_full
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
    localparam logic [SW-1:0] SUM_DEPTH = SW'(DEPTH);
    localparam logic [AW-1:0] IDX_LAST  = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic          ok_reg, empty_reg, full_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [ENTRIES_W-1:0] entries_reg;

    logic          not_full, not_empty, ok_now;
    logic [SW-1:0] sum_ins, sum_pk;
    logic [AW-1:0] tail_ins, tail_pk, head_dec, head_inc;
    logic [CW-1:0] count_m1;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [ELEM_WIDTH-1:0] elem_in, elem_out;
    logic [DATA_W-1:0]     data_pk;
    logic [ENTRIES_W-1:0]  entries_now, entries_cur;

    assign not_full  = count_reg != CNT_FULL;
    assign not_empty = count_reg != '0;
    assign count_m1  = count_reg - CW'(1);

    assign sum_ins  = SW'(head_reg) + SW'(count_reg);
    assign sum_pk   = SW'(head_reg) + SW'(count_m1);
    assign tail_ins = (sum_ins >= SUM_DEPTH) ? AW'(sum_ins - SUM_DEPTH) : AW'(sum_ins);
    assign tail_pk  = (sum_pk >= SUM_DEPTH) ? AW'(sum_pk - SUM_DEPTH) : AW'(sum_pk);
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - AW'(1);
    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + AW'(1);

    assign status.peek_hit = not_empty &&
                             (req_type == REQ_PEEK_HEAD || req_type == REQ_PEEK_TAIL);

    always_comb
    begin
        ok_now     = 1'b0;
        head_next  = head_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = tail_ins;
        raddr      = head_reg;
        case (req_t'(req_type))
            REQ_INS_HEAD:
            begin
                ok_now = not_full;
                waddr  = head_dec;
                if (not_full)
                begin
                    we         = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_INS_TAIL:
            begin
                ok_now = not_full;
                if (not_full)
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_PEEK_HEAD:
            begin
                ok_now = not_empty;
            end
            REQ_PEEK_TAIL:
            begin
                ok_now = not_empty;
                raddr  = tail_pk;
            end
            REQ_REM_HEAD:
            begin
                ok_now = not_empty;
                if (not_empty)
                begin
                    head_next  = head_inc;
                    count_next = count_m1;
                end
            end
            REQ_REM_TAIL:
            begin
                ok_now = not_empty;
                if (not_empty)
                begin
                    count_next = count_m1;
                end
            end
            default:
            begin
                ok_now = 1'b0;
            end
        endcase
    end

    assign re = cmd.issue_read;

    // element masked to ELEM_WIDTH on write, zero-extended to DATA_W on read
    for (genvar i = 0; i < ELEM_WIDTH; i++)
    begin : g_elem_in
        if (i < VALUE_W)
        begin : g_bit
            assign elem_in[i] = value[i];
        end
        else
        begin : g_zero
            assign elem_in[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < DATA_W; i++)
    begin : g_data_pk
        if (i < ELEM_WIDTH)
        begin : g_bit
            assign data_pk[i] = elem_out[i];
        end
        else
        begin : g_zero
            assign data_pk[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < ENTRIES_W; i++)
    begin : g_entries
        if (i < CW)
        begin : g_bit
            assign entries_now[i] = count_next[i];
            assign entries_cur[i] = count_reg[i];
        end
        else
        begin : g_zero
            assign entries_now[i] = 1'b0;
            assign entries_cur[i] = 1'b0;
        end
    end

    dq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.accept && we),
        .waddr (waddr),
        .wdata (elem_in),
        .re    (re),
        .raddr (raddr),
        .rdata (elem_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            ok_reg      <= ok_now;
            data_reg    <= '0;
            entries_reg <= entries_now;
            empty_reg   <= count_next == '0;
            full_reg    <= count_next == CNT_FULL;
        end
        else if (cmd.load_peek)
        begin
            ok_reg      <= 1'b1;
            data_reg    <= data_pk;
            entries_reg <= entries_cur;
            empty_reg   <= count_reg == '0;
            full_reg    <= count_reg == CNT_FULL;
        end
    end

    assign ok       = ok_reg;
    assign data     = data_reg;
    assign entries  = entries_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

endmodule

[design/double_ended_queue.sv]
// Bounded double-ended queue on a ring store. Every request (insert, peek or
// remove at either end) yields one result transaction. Inserts, removes and
// failed requests load the result directly; a successful peek first reads the
// element store, whose read port is registered. A new request is taken while the
// previous result waits, as long as the result register will be free. The store
// needs no clearing after reset. Depends on dq_pkg, dq_ctrl, dq_datapath.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = dq_pkg::ELEM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // ok, data[31:0], entries[4:0], is_empty, is_full
);
    import dq_pkg::*;

    dq_cmd_t    cmd;
    dq_status_t status;

    logic                 ok, is_empty, is_full;
    logic [DATA_W-1:0]    data;
    logic [ENTRIES_W-1:0] entries;

    dq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (s_axis_tuser),
        .value    (s_axis_tdata),
        .cmd      (cmd),
        .status   (status),
        .ok       (ok),
        .data     (data),
        .entries  (entries),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    assign m_axis_tdata = {is_full, is_empty, entries, data, ok};

endmodule

[design/dq_checker.sv]
// Port-level checks for double_ended_queue, attached by bind.
// Depends on double_ended_queue.
module dq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[38] == (m_axis_tdata[37:33] == 5'd0))
        else $error("empty flag disagrees with entry count");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[38] && m_axis_tdata[39]))
        else $error("empty and full both set");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("failed request carries data");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
